### rtl/hk3_pkg.sv
// hk3_pkg: shared types, constants and the per-level octant step of the
// 3D Hilbert key encoder. No dependencies.

package hk3_pkg;

	localparam int COORD_W          = 21;
	localparam int KEY_W            = 63;
	localparam int LEVELS_DEF       = 21;
	localparam int LEVELS_PER_STAGE = 3;
	localparam int MANT_LSB         = 2;

	localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [31:0] TWO_BITS = 32'h4000_0000;

	localparam logic [2:0] OCT_0 = 3'd0;
	localparam logic [2:0] OCT_1 = 3'd1;
	localparam logic [2:0] OCT_2 = 3'd2;
	localparam logic [2:0] OCT_3 = 3'd3;
	localparam logic [2:0] OCT_4 = 3'd4;
	localparam logic [2:0] OCT_5 = 3'd5;
	localparam logic [2:0] OCT_6 = 3'd6;
	localparam logic [2:0] OCT_7 = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] c;
	} coord_t;

	typedef struct packed {
		coord_t            crd;
		logic [KEY_W-1:0]  key;
		logic              range_error;
	} stage_t;

	typedef struct packed {
		coord_t     crd;
		logic [2:0] code;
	} level_t;

	function automatic logic out_of_range(input logic [31:0] v);
		return (v < ONE_BITS) || (v >= TWO_BITS);
	endfunction

	// one level: octant code from bit pos, then rotate/reflect the words
	function automatic level_t level_step(input coord_t ci, input logic [4:0] pos);
		level_t r;
		logic   hx;
		logic   hy;
		logic   hz;
		hx = ci.a[pos];
		hy = ci.b[pos];
		hz = ci.c[pos];
		r.crd = ci;
		if (hx && !hy) begin
			r.crd.a = ~ci.a;
			r.crd.b = ~ci.b;
			r.code  = hz ? OCT_4 : OCT_3;
		end else if (hy && hz) begin
			r.crd.a = ci.b;
			r.crd.b = ~ci.c;
			r.crd.c = ~ci.a;
			r.code  = hx ? OCT_5 : OCT_6;
		end else if (hy) begin
			r.crd.c = ci.a;
			r.crd.a = ci.b;
			r.crd.b = ci.c;
			r.code  = hx ? OCT_2 : OCT_1;
		end else if (hz) begin
			r.crd.b = ci.a;
			r.crd.a = ~ci.c;
			r.crd.c = ~ci.b;
			r.code  = OCT_7;
		end else begin
			r.crd.b = ci.a;
			r.crd.a = ci.c;
			r.crd.c = ci.b;
			r.code  = OCT_0;
		end
		return r;
	endfunction

endpackage

### rtl/hk3_stage.sv
// hk3_stage: one pipeline stage, walks NLEV Hilbert levels from level FIRST
// and registers the result. Depends on hk3_pkg.

module hk3_stage #(
	parameter int FIRST = 0,
	parameter int NLEV  = hk3_pkg::LEVELS_PER_STAGE
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	input  hk3_pkg::stage_t up_data,
	input  logic            dn_en,
	output logic            en,
	output logic            valid_s1,
	output hk3_pkg::stage_t data_s1
);

	hk3_pkg::stage_t nxt;

	assign en = !valid_s1 || dn_en;

	always_comb begin
		hk3_pkg::level_t lv;
		nxt = up_data;
		for (int l = 0; l < NLEV; l++) begin
			lv = hk3_pkg::level_step(nxt.crd, 5'(hk3_pkg::COORD_W - 1 - FIRST - l));
			nxt.crd = lv.crd;
			nxt.key = {nxt.key[hk3_pkg::KEY_W-4:0], lv.code};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

### rtl/hilbert_3d_key_encode_top.sv
// hilbert_3d_key_encode_top: 3D Hilbert key encoder, a chain of hk3_stage
// pipeline stages. Depends on hk3_pkg and hk3_stage.
//
// Request channel: req_valid / req_stall with x_bits, y_bits, z_bits, the
// IEEE single patterns of the coordinates, expected in [1,2). Mantissa bits
// 22..2 of each give 21 bits per axis.
// Result channel: key_valid / key_stall with key (3 bits per level, first
// level most significant) and range_error, set when any pattern is outside
// [1,2); the key is then still built from the mantissa bits.
// Each stage walks up to three levels (the last may walk fewer) and registers
// its result. Throughput: one request per cycle while key_stall is low.
// A stalled result holds; stages behind a bubble keep filling, and once the
// chain is full req_stall follows key_stall.
// Reset clears all stage valid bits; the chain is empty and ready at once.

module hilbert_3d_key_encode_top #(
	parameter int LEVELS = hk3_pkg::LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [31:0] x_bits,
	input  logic [31:0] y_bits,
	input  logic [31:0] z_bits,
	output logic        key_valid,
	input  logic        key_stall,
	output logic [62:0] key,
	output logic        range_error
);

	localparam int LPS     = hk3_pkg::LEVELS_PER_STAGE;
	localparam int NSTAGES = (LEVELS + LPS - 1) / LPS;

	hk3_pkg::stage_t st_data  [NSTAGES+1];
	logic            st_valid [NSTAGES+1];
	logic            st_en    [NSTAGES+1];

	always_comb begin
		st_data[0].crd.a = x_bits[hk3_pkg::MANT_LSB +: hk3_pkg::COORD_W];
		st_data[0].crd.b = y_bits[hk3_pkg::MANT_LSB +: hk3_pkg::COORD_W];
		st_data[0].crd.c = z_bits[hk3_pkg::MANT_LSB +: hk3_pkg::COORD_W];
		st_data[0].key   = '0;
		st_data[0].range_error = hk3_pkg::out_of_range(x_bits)
			|| hk3_pkg::out_of_range(y_bits) || hk3_pkg::out_of_range(z_bits);
	end

	assign st_valid[0]      = req_valid;
	assign st_en[NSTAGES]   = !key_stall;
	assign req_stall        = !st_en[0];

	for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
		localparam int FIRST = s * LPS;
		localparam int NLEV  = (LEVELS - FIRST < LPS) ? (LEVELS - FIRST) : LPS;
		hk3_stage #(
			.FIRST (FIRST),
			.NLEV  (NLEV)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (st_valid[s]),
			.up_data  (st_data[s]),
			.dn_en    (st_en[s+1]),
			.en       (st_en[s]),
			.valid_s1 (st_valid[s+1]),
			.data_s1  (st_data[s+1])
		);
	end

	assign key_valid   = st_valid[NSTAGES];
	assign key         = st_data[NSTAGES].key;
	assign range_error = st_data[NSTAGES].range_error;

endmodule
